@@ hw/rtl/acp_pkg.sv @@
// ----------------------------------------------------------------------------
// acp_pkg
// Types, codes and the colour palette shared by the escape cell parser.
// ----------------------------------------------------------------------------
package acp_pkg;

  // Parse mode of the byte stream (code 3 is unused and treated as text)
  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } mode_e;

  // Kind of an emitted display cell
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_BS    = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_HOME  = 2'd3
  } cell_kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SECOND,
    ST_SGR_RD,
    ST_SGR_EX,
    ST_TC_RD,
    ST_TC_EX
  } ctl_state_e;

  // Byte codes
  localparam logic [7:0] CHAR_ESC      = 8'h1B;
  localparam logic [7:0] CHAR_BS       = 8'h08;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_SEMI     = 8'h3B;
  localparam logic [7:0] CHAR_QMARK    = 8'h3F;
  localparam logic [7:0] CHAR_SGR      = 8'h6D;  // 'm'
  localparam logic [7:0] CHAR_ERASE    = 8'h4A;  // 'J'
  localparam logic [7:0] CHAR_HOME     = 8'h48;  // 'H'
  localparam logic [7:0] CHAR_DIGIT0   = 8'h30;
  localparam logic [7:0] CHAR_DIGIT9   = 8'h39;
  localparam logic [7:0] CHAR_NONE     = 8'h00;

  // Parameter handling
  localparam int unsigned PARAM_W   = 16;
  localparam logic [PARAM_W-1:0] PARAM_SAT    = 16'hFFFF;
  localparam logic [PARAM_W-1:0] ERASE_ALL    = 16'd2;
  localparam logic [PARAM_W-1:0] SGR_RESET    = 16'd0;
  localparam logic [PARAM_W-1:0] SGR_FG_TRUE  = 16'd38;
  localparam logic [PARAM_W-1:0] SGR_TRUE_RGB = 16'd2;
  localparam logic [PARAM_W-1:0] SGR_FG_LO    = 16'd30;
  localparam logic [PARAM_W-1:0] SGR_FG_HI    = 16'd37;
  localparam logic [PARAM_W-1:0] SGR_BG_LO    = 16'd40;
  localparam logic [PARAM_W-1:0] SGR_BG_HI    = 16'd47;
  localparam logic [PARAM_W-1:0] SGR_BFG_LO   = 16'd90;
  localparam logic [PARAM_W-1:0] SGR_BFG_HI   = 16'd97;
  localparam logic [PARAM_W-1:0] SGR_BBG_LO   = 16'd100;
  localparam logic [PARAM_W-1:0] SGR_BBG_HI   = 16'd107;

  // Truecolour walk steps (entry offset from the 38)
  localparam logic [2:0] TC_STEP_MODE = 3'd1;
  localparam logic [2:0] TC_STEP_RED  = 3'd2;
  localparam logic [2:0] TC_STEP_GRN  = 3'd3;
  localparam logic [2:0] TC_STEP_BLU  = 3'd4;

  // Colours
  localparam logic [31:0] FG_DEFAULT = 32'hFFFFFFFF;
  localparam logic [31:0] BG_DEFAULT = 32'hFF000000;
  localparam logic [31:0] COLOUR_NONE = 32'h00000000;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // Output cell
  typedef struct packed {
    cell_kind_e  kind;
    logic [7:0]  ch;
    logic [31:0] fg;
    logic [31:0] bg;
    logic        last;
  } cell_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic accept;       // take the input byte
    logic load_second;  // put the held byte in the output register
    logic sgr_apply;    // apply the fetched SGR code, step to next entry
    logic tc_begin;     // start a 38;2;r;g;b walk
    logic tc_next;      // consume one truecolour entry
    logic tc_abort;     // second entry was not 2: treat next entry plainly
    logic walk_end;     // SGR walk finished
  } acp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic two_cells;    // current byte gives two cells
    logic start_sgr;    // current byte is an SGR final
    logic out_free;     // output register can take a cell this cycle
    logic walk_done;    // all stored entries walked
    logic tc_ok;        // fetched entry is 38 with four entries after it
    logic tc_mode2;     // fetched entry is 2
    logic tc_first;     // on the mode entry of a truecolour walk
    logic tc_last;      // on the blue entry of a truecolour walk
  } acp_status_t;

  // 16-colour palette: normal 0-7, bright 8-15
  function automatic logic [31:0] palette(input logic [3:0] idx);
    logic [31:0] c;
    case (idx)
      4'd0:    c = 32'hFF111111;
      4'd1:    c = 32'hFFFF5555;
      4'd2:    c = 32'hFF55FF55;
      4'd3:    c = 32'hFFFFFF55;
      4'd4:    c = 32'hFF5555FF;
      4'd5:    c = 32'hFFFF55FF;
      4'd6:    c = 32'hFF55FFFF;
      4'd7:    c = 32'hFFFFFFFF;
      4'd8:    c = 32'hFF888888;
      4'd9:    c = 32'hFFFF8888;
      4'd10:   c = 32'hFF88FF88;
      4'd11:   c = 32'hFFFFFF88;
      4'd12:   c = 32'hFF8888FF;
      4'd13:   c = 32'hFFFF88FF;
      4'd14:   c = 32'hFF88FFFF;
      default: c = 32'hFFFFFFFF;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/acp_ctrl.sv @@
// ----------------------------------------------------------------------------
// acp_ctrl
// Sequencer: input handshake, second-cell hand-off and the SGR walk.
// ----------------------------------------------------------------------------
module acp_ctrl import acp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  acp_status_t status_i,
  output acp_cmd_t    cmd_o
);

  ctl_state_e state_q, state_d;
  logic       accept;

  // a byte is taken only in idle, with room in the output register
  assign accept = (state_q == ST_IDLE) && in_valid_i && status_i.out_free;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.two_cells) begin
          state_d = ST_SECOND;
        end else if (accept && status_i.start_sgr) begin
          state_d = ST_SGR_RD;
        end
      end
      ST_SECOND: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SGR_RD: begin
        state_d = status_i.walk_done ? ST_IDLE : ST_SGR_EX;
      end
      ST_SGR_EX: begin
        state_d = status_i.tc_ok ? ST_TC_RD : ST_SGR_RD;
      end
      ST_TC_RD: begin
        state_d = ST_TC_EX;
      end
      ST_TC_EX: begin
        if (status_i.tc_first && !status_i.tc_mode2) begin
          state_d = ST_SGR_RD;
        end else if (status_i.tc_last) begin
          state_d = ST_SGR_RD;
        end else begin
          state_d = ST_TC_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = !status_i.out_free;
        cmd_o.accept = accept;
      end
      ST_SECOND: begin
        cmd_o.load_second = status_i.out_free;
      end
      ST_SGR_RD: begin
        cmd_o.walk_end = status_i.walk_done;
      end
      ST_SGR_EX: begin
        cmd_o.tc_begin  = status_i.tc_ok;
        cmd_o.sgr_apply = !status_i.tc_ok;
      end
      ST_TC_RD: begin
        cmd_o = '0;
      end
      ST_TC_EX: begin
        cmd_o.tc_abort = status_i.tc_first && !status_i.tc_mode2;
        cmd_o.tc_next  = !(status_i.tc_first && !status_i.tc_mode2);
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/acp_datapath.sv @@
// ----------------------------------------------------------------------------
// acp_datapath
// Byte decode, parameter store, colour state and the output cell register.
// ----------------------------------------------------------------------------
module acp_datapath import acp_pkg::*; #(
  parameter int MAX_PARAMS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic [7:0]  char_in_i,
  input  logic        out_stall_i,
  input  acp_cmd_t    cmd_i,
  output acp_status_t status_o,
  output cell_t       cell_o,
  output logic        out_valid_o
);

  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam int IW = $clog2(MAX_PARAMS);

  // control state
  logic          pass_q;
  mode_e         mode_q, mode_d;
  logic [15:0]   acc_q, acc_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   fg_q, fg_d;
  logic [31:0]   bg_q, bg_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [2:0]    step_q, step_d;
  logic          out_valid_q, out_valid_d;

  // payload
  logic [15:0]   mem [MAX_PARAMS];
  logic [15:0]   rdata_q;
  logic [7:0]    red_q, grn_q;
  logic [7:0]    hold_q;
  cell_t         cell_q, cell_d;

  // decode results
  logic          emit;
  logic          two;
  logic          sgr;
  logic          store_req;
  logic          store_we;
  cell_t         first;
  logic [19:0]   acc_x10;
  logic [19:0]   acc_sum;
  logic [CW-1:0] rd_full;
  logic [IW-1:0] rd_addr;
  logic [CW:0]   tc_end;
  logic          out_free;
  logic          load;
  logic [15:0]   off_fg, off_bg, off_bfg, off_bbg;

  assign out_free = !out_valid_q || !out_stall_i;

  // decimal accumulate with saturation
  assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign acc_sum = acc_x10 + {16'd0, char_in_i[3:0]};

  // byte decode
  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    emit      = 1'b0;
    two       = 1'b0;
    sgr       = 1'b0;
    store_req = 1'b0;
    first     = '{kind: KIND_CHAR, ch: char_in_i, fg: fg_q, bg: bg_q, last: 1'b1};
    case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_TEXT;
        if (char_in_i == CHAR_LBRACKET) begin
          mode_d = MODE_CSI;
          acc_d  = '0;
        end else if (pass_q) begin
          emit       = 1'b1;
          two        = 1'b1;
          first.ch   = CHAR_ESC;
          first.last = 1'b0;
        end
      end
      MODE_CSI: begin
        if (char_in_i inside {[CHAR_DIGIT0:CHAR_DIGIT9]}) begin
          acc_d = (acc_sum > {4'd0, PARAM_SAT}) ? PARAM_SAT : acc_sum[15:0];
        end else begin
          case (char_in_i)
            CHAR_QMARK: begin
              // private marker: accepted, no effect on cells
              acc_d = acc_q;
            end
            CHAR_SEMI: begin
              store_req = 1'b1;
              acc_d     = '0;
            end
            CHAR_SGR: begin
              store_req = 1'b1;
              sgr       = 1'b1;
              acc_d     = '0;
              mode_d    = MODE_TEXT;
            end
            CHAR_ERASE: begin
              emit       = (acc_q == ERASE_ALL);
              first.kind = KIND_CLEAR;
              first.ch   = CHAR_NONE;
              acc_d      = '0;
              mode_d     = MODE_TEXT;
            end
            CHAR_HOME: begin
              emit       = 1'b1;
              first.kind = KIND_HOME;
              first.ch   = CHAR_NONE;
              first.fg   = COLOUR_NONE;
              first.bg   = COLOUR_NONE;
              acc_d      = '0;
              mode_d     = MODE_TEXT;
            end
            default: begin
              acc_d  = '0;
              mode_d = MODE_TEXT;
            end
          endcase
        end
      end
      default: begin
        mode_d = MODE_TEXT;
        if (char_in_i == CHAR_ESC) begin
          mode_d = MODE_ESC;
        end else if (char_in_i == CHAR_BS) begin
          emit       = 1'b1;
          first.kind = KIND_BS;
        end else begin
          emit = 1'b1;
        end
      end
    endcase
  end

  // a full store drops the parameter
  assign store_we = cmd_i.accept && store_req && (count_q < CW'(MAX_PARAMS));

  // parameter count
  always_comb begin
    count_d = count_q;
    if (cmd_i.accept && (mode_q == MODE_ESC) && (char_in_i == CHAR_LBRACKET)) begin
      count_d = '0;
    end else if (store_we) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.walk_end) begin
      count_d = '0;
    end
  end

  // walk pointer and truecolour step
  always_comb begin
    idx_d  = idx_q;
    step_d = step_q;
    if (cmd_i.accept) begin
      idx_d  = '0;
      step_d = '0;
    end else if (cmd_i.sgr_apply) begin
      idx_d = idx_q + CW'(1);
    end else if (cmd_i.tc_begin) begin
      step_d = TC_STEP_MODE;
    end else if (cmd_i.tc_abort) begin
      idx_d  = idx_q + CW'(1);
      step_d = '0;
    end else if (cmd_i.tc_next) begin
      if (step_q == TC_STEP_BLU) begin
        idx_d  = idx_q + CW'(5);
        step_d = '0;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  // SGR colour update from the fetched entry
  assign off_fg  = rdata_q - SGR_FG_LO;
  assign off_bg  = rdata_q - SGR_BG_LO;
  assign off_bfg = rdata_q - SGR_BFG_LO;
  assign off_bbg = rdata_q - SGR_BBG_LO;

  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cmd_i.sgr_apply) begin
      if (rdata_q == SGR_RESET) begin
        fg_d = FG_DEFAULT;
        bg_d = BG_DEFAULT;
      end else if (rdata_q inside {[SGR_FG_LO:SGR_FG_HI]}) begin
        fg_d = palette({1'b0, off_fg[2:0]});
      end else if (rdata_q inside {[SGR_BFG_LO:SGR_BFG_HI]}) begin
        fg_d = palette({1'b1, off_bfg[2:0]});
      end else if (rdata_q inside {[SGR_BG_LO:SGR_BG_HI]}) begin
        bg_d = palette({1'b0, off_bg[2:0]});
      end else if (rdata_q inside {[SGR_BBG_LO:SGR_BBG_HI]}) begin
        bg_d = palette({1'b1, off_bbg[2:0]});
      end
    end else if (cmd_i.tc_next && (step_q == TC_STEP_BLU)) begin
      fg_d = {ALPHA_OPAQUE, red_q, grn_q, rdata_q[7:0]};
    end
  end

  // output register
  assign load = (cmd_i.accept && emit) || cmd_i.load_second;

  always_comb begin
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end
    cell_d = first;
    if (cmd_i.load_second) begin
      cell_d = '{kind: KIND_CHAR, ch: hold_q, fg: fg_q, bg: bg_q, last: 1'b1};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q      <= 1'b0;
      mode_q      <= MODE_TEXT;
      acc_q       <= '0;
      count_q     <= '0;
      fg_q        <= FG_DEFAULT;
      bg_q        <= BG_DEFAULT;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pass_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
      end
      count_q     <= count_d;
      fg_q        <= fg_d;
      bg_q        <= bg_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // parameter store, registered read at walk pointer plus step
  assign rd_full = idx_q + CW'(step_q);
  assign rd_addr = rd_full[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      mem[count_q[IW-1:0]] <= acc_q;
    end
    if (rd_full < CW'(MAX_PARAMS)) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hold_q <= char_in_i;
    end
    if (cmd_i.tc_next && (step_q == TC_STEP_RED)) begin
      red_q <= rdata_q[7:0];
    end
    if (cmd_i.tc_next && (step_q == TC_STEP_GRN)) begin
      grn_q <= rdata_q[7:0];
    end
    if (load) begin
      cell_q <= cell_d;
    end
  end

  // status
  assign tc_end = {1'b0, idx_q} + (CW+1)'(4);

  assign status_o.two_cells = two;
  assign status_o.start_sgr = sgr;
  assign status_o.out_free  = out_free;
  assign status_o.walk_done = (idx_q >= count_q);
  assign status_o.tc_ok     = (rdata_q == SGR_FG_TRUE) && (tc_end < {1'b0, count_q});
  assign status_o.tc_mode2  = (rdata_q == SGR_TRUE_RGB);
  assign status_o.tc_first  = (step_q == TC_STEP_MODE);
  assign status_o.tc_last   = (step_q == TC_STEP_BLU);

  assign cell_o      = cell_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/ansi_escape_cell_parser.sv @@
// ----------------------------------------------------------------------------
// ansi_escape_cell_parser
// Terminal byte stream to display cells, with CSI/SGR colour handling.
//
//   channel  direction  handshake              beat
//   in       input      in_valid_i/in_stall_o   char_in_i
//   out      output     out_valid_o/out_stall_i cell_kind_o .. last_cell_o
//   cfg      input      cfg_we_i                cfg_wdata_i (pass escapes)
//
// An ESC pair passed through gives two cells, one at a time through the single
// output register. An SGR final walks the stored entries, each read and then
// applied; a 38 whose second entry is not 2 has that entry read once more.
// The walk pace is set by the one registered read port of the store.
// Reset is asynchronous and needs no clearing pass.
// Input is stalled during the second cell and the walk, and while the
// output register holds a stalled cell.
// ----------------------------------------------------------------------------
module ansi_escape_cell_parser import acp_pkg::*; #(
  parameter int MAX_PARAMS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] cell_kind_o,
  output logic [7:0] cell_char_o,
  output logic [31:0] fg_color_o,
  output logic [31:0] bg_color_o,
  output logic       last_cell_o
);

  acp_cmd_t    cmd;
  acp_status_t status;
  cell_t       out_cell;

  // sequencer
  acp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  acp_datapath #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .char_in_i   (char_in_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cell_o      (out_cell),
    .out_valid_o (out_valid_o)
  );

  // cell fields
  assign cell_kind_o = out_cell.kind;
  assign cell_char_o = out_cell.ch;
  assign fg_color_o  = out_cell.fg;
  assign bg_color_o  = out_cell.bg;
  assign last_cell_o = out_cell.last;

endmodule

@@ hw/rtl/acp_checker.sv @@
// ----------------------------------------------------------------------------
// acp_checker
// Port-level checks on the cell stream, bound to the parser top level.
// ----------------------------------------------------------------------------
module acp_checker import acp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [1:0]  cell_kind_i,
  input logic [7:0]  cell_char_i,
  input logic [31:0] fg_color_i,
  input logic [31:0] bg_color_i,
  input logic        last_cell_i
);

  // a stalled cell beat stays valid with its byte, foreground and last flag held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(cell_char_i)
      && $stable(fg_color_i) && $stable(last_cell_i))
    else $error("stalled cell beat changed");

  // home cells carry no byte and no colour
  a_home_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (cell_kind_i == KIND_HOME) |->
      (cell_char_i == CHAR_NONE) && (fg_color_i == COLOUR_NONE)
      && (bg_color_i == COLOUR_NONE) && last_cell_i)
    else $error("home cell not blank");

  // clear cells carry no byte and are always the only cell of their byte
  a_clear_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (cell_kind_i == KIND_CLEAR) |->
      (cell_char_i == CHAR_NONE) && last_cell_i)
    else $error("clear cell malformed");

  // backspace cells carry the backspace byte
  a_bs_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (cell_kind_i == KIND_BS) |-> (cell_char_i == CHAR_BS) && last_cell_i)
    else $error("backspace cell malformed");

  // only a passed-through ESC opens a two-cell byte
  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_cell_i |-> (cell_kind_i == KIND_CHAR) && (cell_char_i == CHAR_ESC))
    else $error("non-final cell is not an ESC char");

endmodule

bind ansi_escape_cell_parser acp_checker u_acp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .cell_kind_i (cell_kind_o),
  .cell_char_i (cell_char_o),
  .fg_color_i  (fg_color_o),
  .bg_color_i  (bg_color_o),
  .last_cell_i (last_cell_o)
);

@@ bench/ansi_escape_cell_parser_test.sv @@
// ----------------------------------------------------------------------------
// ansi_escape_cell_parser_test
// Self-checking bench for the terminal escape cell parser. Byte streams of
// plain text, backspaces, SGR colour sequences (palette, bright and
// truecolour, store overflow), erase and home requests, unknown escapes and
// broken CSI sequences are fed through the input channel. A behavioural
// parser predicts the cells of every accepted beat; the output monitor
// checks each cell field by field. Phases vary the pass-through register
// and the idle/stall pattern on both channels, one with a long hold-off.
// ----------------------------------------------------------------------------
module ansi_escape_cell_parser_test;
  import acp_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 11;
  localparam int STORE_DEPTH    = 16;
  localparam int N_PHASES       = 8;
  localparam int PHASE_BYTES    = 155;
  localparam int SETTLE_CYCLES  = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_PHASE     = 2;
  localparam int TIMEOUT_CYCLES = 400000;

  // 16-entry ANSI colour table, entry 15 in the top word
  localparam logic [16*32-1:0] ANSI_COLOURS = {
    32'hFFFFFFFF, 32'hFF88FFFF, 32'hFFFF88FF, 32'hFF8888FF,
    32'hFFFFFF88, 32'hFF88FF88, 32'hFFFF8888, 32'hFF888888,
    32'hFFFFFFFF, 32'hFF55FFFF, 32'hFFFF55FF, 32'hFF5555FF,
    32'hFFFFFF55, 32'hFF55FF55, 32'hFFFF5555, 32'hFF111111
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_in_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  cell_kind_o;
  logic [7:0]  cell_char_o;
  logic [31:0] fg_color_o;
  logic [31:0] bg_color_o;
  logic        last_cell_o;

  // Stimulus and expectation stores
  logic [7:0] pending_bytes[$];
  cell_t      cells_due[$];

  // Shadow parser state
  mode_e       term_mode = MODE_TEXT;
  logic [15:0] acc_param = '0;
  logic [15:0] sgr_params[STORE_DEPTH];
  int unsigned n_params  = 0;
  logic [31:0] cur_fg    = FG_DEFAULT;
  logic [31:0] cur_bg    = BG_DEFAULT;
  logic        pass_esc  = 1'b0;

  // Run control and tallies
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go        = 1'b0;
  logic        hold_on        = 1'b0;
  int unsigned hold_count     = 0;
  int unsigned queued_total   = 0;
  int unsigned bytes_taken    = 0;
  int unsigned cells_checked  = 0;
  int unsigned sgr_finals     = 0;
  int unsigned kind_seen[4]   = '{0, 0, 0, 0};
  int unsigned mismatches     = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  ansi_escape_cell_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_kind_o (cell_kind_o),
    .cell_char_o (cell_char_o),
    .fg_color_o  (fg_color_o),
    .bg_color_o  (bg_color_o),
    .last_cell_o (last_cell_o)
  );

  function automatic logic [31:0] ansi_colour(int unsigned idx);
    return ANSI_COLOURS[idx*32 +: 32];
  endfunction

  function automatic cell_t make_cell(cell_kind_e kind, logic [7:0] ch,
                                      logic [31:0] fg, logic [31:0] bg);
    cell_t c;
    c.kind = kind;
    c.ch   = ch;
    c.fg   = fg;
    c.bg   = bg;
    c.last = 1'b0;
    return c;
  endfunction

  // Extra parameters beyond the store depth are dropped
  function void store_acc();
    if (n_params < STORE_DEPTH) begin
      sgr_params[n_params] = acc_param;
      n_params++;
    end
  endfunction

  // Walk the stored SGR codes and update the current colours
  function void apply_sgr_codes();
    int unsigned i;
    logic [15:0] p;
    sgr_finals++;
    for (i = 0; i < n_params; i++) begin
      p = sgr_params[i];
      if (p == SGR_RESET) begin
        cur_fg = FG_DEFAULT;
        cur_bg = BG_DEFAULT;
      end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
        cur_fg = ansi_colour(32'(p - SGR_FG_LO));
      end else if (p >= SGR_BFG_LO && p <= SGR_BFG_HI) begin
        cur_fg = ansi_colour(32'(p - SGR_BFG_LO) + 8);
      end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
        cur_bg = ansi_colour(32'(p - SGR_BG_LO));
      end else if (p >= SGR_BBG_LO && p <= SGR_BBG_HI) begin
        cur_bg = ansi_colour(32'(p - SGR_BBG_LO) + 8);
      end else if (p == SGR_FG_TRUE) begin
        // 38;2;r;g;b needs all four entries present
        if (i + 4 < n_params && sgr_params[i + 1] == SGR_TRUE_RGB) begin
          cur_fg = {ALPHA_OPAQUE, sgr_params[i + 2][7:0],
                    sgr_params[i + 3][7:0], sgr_params[i + 4][7:0]};
          i += 4;
        end
      end
    end
  endfunction

  // Predict the cells caused by one accepted byte
  function void parse_byte(logic [7:0] c);
    cell_t       made[2];
    int          n;
    int unsigned v;
    n = 0;
    case (term_mode)
      MODE_ESC: begin
        if (c == CHAR_LBRACKET) begin
          term_mode = MODE_CSI;
          n_params  = 0;
          acc_param = '0;
        end else begin
          if (pass_esc) begin
            made[0] = make_cell(KIND_CHAR, CHAR_ESC, cur_fg, cur_bg);
            made[1] = make_cell(KIND_CHAR, c, cur_fg, cur_bg);
            n = 2;
          end
          term_mode = MODE_TEXT;
        end
      end
      MODE_CSI: begin
        if (c >= CHAR_DIGIT0 && c <= CHAR_DIGIT9) begin
          v = acc_param * 10 + (c - CHAR_DIGIT0);
          acc_param = (v > PARAM_SAT) ? PARAM_SAT : v[15:0];
        end else if (c == CHAR_QMARK) begin
          // private marker: no effect on the cells
        end else if (c == CHAR_SEMI) begin
          store_acc();
          acc_param = '0;
        end else if (c == CHAR_SGR) begin
          store_acc();
          apply_sgr_codes();
          acc_param = '0;
          n_params  = 0;
          term_mode = MODE_TEXT;
        end else if (c == CHAR_ERASE) begin
          if (acc_param == ERASE_ALL) begin
            made[0] = make_cell(KIND_CLEAR, CHAR_NONE, cur_fg, cur_bg);
            n = 1;
          end
          acc_param = '0;
          term_mode = MODE_TEXT;
        end else if (c == CHAR_HOME) begin
          made[0] = make_cell(KIND_HOME, CHAR_NONE, COLOUR_NONE, COLOUR_NONE);
          n = 1;
          acc_param = '0;
          term_mode = MODE_TEXT;
        end else begin
          // any other byte, ESC too, abandons the sequence
          acc_param = '0;
          term_mode = MODE_TEXT;
        end
      end
      default: begin
        term_mode = MODE_TEXT;
        if (c == CHAR_ESC) begin
          term_mode = MODE_ESC;
        end else if (c == CHAR_BS) begin
          made[0] = make_cell(KIND_BS, c, cur_fg, cur_bg);
          n = 1;
        end else begin
          made[0] = make_cell(KIND_CHAR, c, cur_fg, cur_bg);
          n = 1;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      made[k].last = (k == n - 1);
      cells_due.push_back(made[k]);
    end
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Stimulus builders
  function void push_byte(logic [7:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endfunction

  function void push_text(string s);
    for (int k = 0; k < s.len(); k++) push_byte(s[k]);
  endfunction

  function void csi(string body);
    push_byte(CHAR_ESC);
    push_byte(CHAR_LBRACKET);
    push_text(body);
  endfunction

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid_i || cells_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Input driver: predicts on every accepted beat, then offers the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_byte(char_in_i);
        bytes_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          char_in_i  <= pending_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Shadow copy of the pass-through register
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) pass_esc = cfg_wdata_i;
  end

  // Long hold-off once, so the block backs up into the input
  always @(posedge clk_i) begin : hold_off
    if (rst_ni && hold_go && hold_count < HOLD_CYCLES) begin
      hold_on    <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      hold_on <= 1'b0;
    end
  end

  // Output monitor and receiver stall
  always @(posedge clk_i) begin : monitor
    cell_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (cells_due.size() == 0) begin
          $error("unexpected cell: kind %0d char 0x%0h", cell_kind_o, cell_char_o);
          mismatches++;
        end else begin
          want = cells_due.pop_front();
          compare_field("cell_kind", 32'(want.kind), 32'(cell_kind_o));
          compare_field("cell_char", 32'(want.ch), 32'(cell_char_o));
          compare_field("fg_color", want.fg, fg_color_o);
          compare_field("bg_color", want.bg, bg_color_o);
          compare_field("last_cell", 32'(want.last), 32'(last_cell_o));
          kind_seen[want.kind]++;
          cells_checked++;
        end
      end
      if (hold_on) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Phases: register setting, idle pattern, then byte traffic
  initial begin : stimulus
    string       body;
    int unsigned target;
    int unsigned pick;
    int unsigned slots;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= (ph >= N_PHASES / 2);
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      @(negedge clk_i);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (ph == HOLD_PHASE) hold_go = 1'b1;

      // Directed opener: byte extremes, erase, home, bright and truecolour
      // SGR with saturation and masking, unknown escape, aborted CSI
      if (ph == 0) begin
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CHAR_BS);
        csi("2J");
        csi("H");
        csi("?99999;107;38;2;511;1;256m");
        push_text("A");
        push_byte(CHAR_ESC);
        push_text("x");
        csi("5z");
        csi("12");
        push_byte(CHAR_ESC);
        push_text("B");
      end

      target = queued_total + PHASE_BYTES;
      while (queued_total < target) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          // raw noise byte
          push_byte(8'($urandom_range(255)));
        end else if (pick < 35) begin
          // text run with backspaces
          repeat ($urandom_range(1, 6))
            push_byte(($urandom_range(3) == 0) ? CHAR_BS : 8'($urandom_range(32, 126)));
        end else if (pick < 62) begin
          // SGR sequence, sometimes long enough to overflow the store
          body  = ($urandom_range(7) == 0) ? "?" : "";
          slots = ($urandom_range(7) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 4);
          for (int k = 0; k < slots; k++) begin
            if (k > 0) body = {body, ";"};
            case ($urandom_range(9))
              0: body = {body, "0"};
              1: body = {body, $sformatf("%0d", $urandom_range(30, 37))};
              2: body = {body, $sformatf("%0d", $urandom_range(90, 97))};
              3: body = {body, $sformatf("%0d", $urandom_range(40, 47))};
              4: body = {body, $sformatf("%0d", $urandom_range(100, 107))};
              5: body = {body, $sformatf("38;2;%0d;%0d;%0d", $urandom_range(300),
                                         $urandom_range(300), $urandom_range(300))};
              6: body = {body, $sformatf("38;%0d;%0d", $urandom_range(5),
                                         $urandom_range(255))};
              7: body = {body, $sformatf("%0d", $urandom_range(99999))};
              8: body = body;
              default: body = {body, $sformatf("%0d", $urandom_range(120))};
            endcase
          end
          csi({body, "m"});
          repeat ($urandom_range(1, 2)) push_byte(8'($urandom_range(32, 126)));
        end else if (pick < 74) begin
          // erase and home requests
          case ($urandom_range(5))
            0: csi("2J");
            1: csi("J");
            2: csi($sformatf("%0dJ", $urandom_range(9)));
            3: csi("?2J");
            4: csi("H");
            default: csi($sformatf("%0d;%0dH", $urandom_range(99), $urandom_range(99)));
          endcase
        end else if (pick < 87) begin
          // ESC followed by anything
          push_byte(CHAR_ESC);
          push_byte(8'($urandom_range(255)));
        end else begin
          // CSI cut short by an unlisted byte or an ESC
          csi($sformatf("%0d", $urandom_range(999)));
          push_byte(($urandom_range(3) == 0) ? CHAR_ESC : 8'($urandom_range(255)));
        end
      end
    end
    drain();
    $display("Covered %0d bytes in %0d phases, both pass-through settings, %0d SGR finals,",
             bytes_taken, N_PHASES, sgr_finals);
    $display("%0d cells checked (char %0d, backspace %0d, clear %0d, home %0d), one %0d-cycle hold-off",
             cells_checked, kind_seen[KIND_CHAR], kind_seen[KIND_BS],
             kind_seen[KIND_CLEAR], kind_seen[KIND_HOME], HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("timeout: %0d cells still expected", cells_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
